### design/ticket_number_queue_unit_macros.svh
// Assertion macros shared by the ticket number queue RTL.
`ifndef TICKET_NUMBER_QUEUE_UNIT_MACROS_SVH
`define TICKET_NUMBER_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define TNQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TNQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TNQ_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TNQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### design/tnq_pkg.sv
// Types and constants shared by the ticket number queue modules.
`timescale 1ns / 1ps
`default_nettype none

package tnq_pkg;

  typedef enum logic [2:0] {
    OP_TAKE   = 3'd0,
    OP_CALL   = 3'd1,
    OP_SKIP   = 3'd2,
    OP_CANCEL = 3'd3,
    OP_STATUS = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_SCAN = 2'd1,
    RD_REAR = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_CANCEL,
    S_RD_FRONT,
    S_RD_REAR,
    S_MUL,
    S_OUTPUT
  } state_t;

  localparam logic [9:0] SERVICE_TIME_RESET = 10'd5;

  typedef struct packed {
    logic    load;
    logic    take;
    logic    full;
    logic    empty;
    logic    pop;
    logic    push_back;
    logic    scan_init;
    logic    scan;
    logic    scan_end;
    rd_sel_t rd_sel;
    logic    front_cap;
    logic    rear_cap;
    logic    mult;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       is_empty;
    logic       is_full;
    logic       scan_done;
    logic       out_busy;
  } sts_t;

endpackage

`default_nettype wire

### design/tnq_if.sv
// Request and result channel interfaces of the ticket number queue.
`timescale 1ns / 1ps
`default_nettype none

interface tnq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] ticket_number;

  modport source(output valid, output opcode, output ticket_number, input ready);
  modport sink(input valid, input opcode, input ticket_number, output ready);
endinterface

interface tnq_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] ticket;
  logic [1:0]  status;
  logic [6:0]  queue_count;
  logic [15:0] front_ticket;
  logic [15:0] rear_ticket;
  logic [14:0] wait_average;
  logic [15:0] finish_estimate;

  modport source(output valid, output ticket, output status, output queue_count,
                 output front_ticket, output rear_ticket, output wait_average,
                 output finish_estimate, input ready);
  modport sink(input valid, input ticket, input status, input queue_count,
               input front_ticket, input rear_ticket, input wait_average,
               input finish_estimate, output ready);
endinterface

`default_nettype wire

### design/tnq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tnq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/tnq_datapath.sv
// Datapath: ticket store, queue pointers, cancel compaction and result register.
`timescale 1ns / 1ps
`default_nettype none

module tnq_datapath #(
  parameter int DEPTH = 64,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [9:0]    cfg_data,
  input  wire logic [2:0]    in_opcode,
  input  wire logic [15:0]   in_number,
  input  wire tnq_pkg::cmd_t cmd,
  output tnq_pkg::sts_t      sts,
  tnq_res_if.source          res
);

  localparam int PW  = CW + 10;
  localparam int PXW = (PW > 16) ? PW : 16;

  logic [9:0]            service_time;
  logic [IW-1:0]         head;
  logic [CW-1:0]         count;
  logic [15:0]           counter;
  logic [2:0]            op;
  logic [15:0]           num;
  logic [CW-1:0]         scan_i;
  logic [CW-1:0]         kept;
  logic                  rd_pend;
  logic [15:0]           res_ticket;
  tnq_pkg::status_t      res_status;
  logic [15:0]           front;
  logic [15:0]           rear;
  logic [PXW-1:0]        prod;

  logic [IW-1:0]         tail_slot;
  logic [IW-1:0]         scan_slot;
  logic [IW-1:0]         keep_slot;
  logic [IW-1:0]         rear_slot;
  logic [IW-1:0]         head_next;
  logic                  scan_more;
  logic                  keep_hit;
  logic                  is_empty;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [15:0]           ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [15:0]           ram_rdata;

  // Position of the entry at a given offset behind the head, circular.
  function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign tail_slot = wrap_slot(head, count);
  assign scan_slot = wrap_slot(head, scan_i);
  assign keep_slot = wrap_slot(head, kept);
  assign rear_slot = wrap_slot(head, count - CW'(1));
  assign head_next = wrap_slot(head, CW'(1));
  assign scan_more = (scan_i < count);
  assign keep_hit  = rd_pend && (ram_rdata != num);
  assign is_empty  = (count == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_slot;
    ram_wdata = counter + 16'd1;
    if (cmd.take) begin
      ram_we = 1'b1;
    end else if (cmd.push_back) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.scan && keep_hit) begin
      ram_we    = 1'b1;
      ram_waddr = keep_slot;
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      tnq_pkg::RD_SCAN: ram_raddr = scan_slot;
      tnq_pkg::RD_REAR: ram_raddr = rear_slot;
      default:          ram_raddr = head;
    endcase
  end

  tnq_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Queue pointers, configuration and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      service_time <= tnq_pkg::SERVICE_TIME_RESET;
      head         <= '0;
      count        <= '0;
      counter      <= '0;
      rd_pend      <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        service_time <= cfg_data;
      end
      if (cmd.take) begin
        counter <= counter + 16'd1;
        count   <= count + CW'(1);
      end
      if (cmd.pop) begin
        head <= head_next;
        if (!cmd.push_back) begin
          count <= count - CW'(1);
        end
      end
      if (cmd.scan_init) begin
        rd_pend <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend <= scan_more;
      end
      if (cmd.scan_end) begin
        count <= kept;
      end
      if (cmd.out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Working values and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= in_opcode;
      num        <= in_number;
      res_ticket <= '0;
      res_status <= tnq_pkg::ST_OK;
    end
    if (cmd.take) begin
      res_ticket <= counter + 16'd1;
    end
    if (cmd.full) begin
      res_status <= tnq_pkg::ST_FULL;
    end
    if (cmd.empty) begin
      res_status <= tnq_pkg::ST_EMPTY;
    end
    if (cmd.pop) begin
      res_ticket <= ram_rdata;
    end
    if (cmd.scan_init) begin
      scan_i <= '0;
      kept   <= '0;
    end else if (cmd.scan) begin
      if (scan_more) begin
        scan_i <= scan_i + CW'(1);
      end
      if (keep_hit) begin
        kept <= kept + CW'(1);
      end
    end
    if (cmd.scan_end && (kept == count)) begin
      res_status <= tnq_pkg::ST_NOT_FOUND;
    end
    if (cmd.front_cap) begin
      front <= ram_rdata;
    end
    if (cmd.rear_cap) begin
      rear <= ram_rdata;
    end
    if (cmd.mult) begin
      prod <= PXW'(count) * PXW'(service_time);
    end
    if (cmd.out_load) begin
      res.ticket          <= res_ticket;
      res.status          <= res_status;
      res.queue_count     <= 7'(count);
      res.front_ticket    <= is_empty ? 16'd0 : front;
      res.rear_ticket     <= is_empty ? 16'd0 : rear;
      res.wait_average    <= is_empty ? 15'd0 : 15'((prod - PXW'(service_time)) >> 1);
      res.finish_estimate <= 16'(prod);
    end
  end

  assign sts.op        = op;
  assign sts.is_empty  = is_empty;
  assign sts.is_full   = (count == CW'(DEPTH));
  assign sts.scan_done = !scan_more && !rd_pend;
  assign sts.out_busy  = res.valid && !res.ready;

endmodule

`default_nettype wire

### design/tnq_ctrl.sv
// Controller: sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module tnq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tnq_pkg::sts_t sts,
  output tnq_pkg::cmd_t      cmd
);

  tnq_pkg::state_t state;
  tnq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tnq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_sel = tnq_pkg::RD_HEAD;
    case (state)
      tnq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tnq_pkg::S_DISPATCH;
        end
      end
      tnq_pkg::S_DISPATCH: begin
        state_next = tnq_pkg::S_RD_FRONT;
        case (sts.op)
          tnq_pkg::OP_TAKE: begin
            if (sts.is_full) begin
              cmd.full = 1'b1;
            end else begin
              cmd.take = 1'b1;
            end
          end
          tnq_pkg::OP_CALL, tnq_pkg::OP_SKIP: begin
            if (sts.is_empty) begin
              cmd.empty = 1'b1;
            end else begin
              // Head entry is read here and consumed in the pop state.
              state_next = tnq_pkg::S_POP;
            end
          end
          tnq_pkg::OP_CANCEL: begin
            if (sts.is_empty) begin
              cmd.empty = 1'b1;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = tnq_pkg::S_CANCEL;
            end
          end
          default: begin
          end
        endcase
      end
      tnq_pkg::S_POP: begin
        cmd.pop       = 1'b1;
        cmd.push_back = (sts.op == tnq_pkg::OP_SKIP);
        state_next    = tnq_pkg::S_RD_FRONT;
      end
      tnq_pkg::S_CANCEL: begin
        if (sts.scan_done) begin
          cmd.scan_end = 1'b1;
          state_next   = tnq_pkg::S_RD_FRONT;
        end else begin
          cmd.scan   = 1'b1;
          cmd.rd_sel = tnq_pkg::RD_SCAN;
        end
      end
      tnq_pkg::S_RD_FRONT: begin
        state_next = tnq_pkg::S_RD_REAR;
      end
      tnq_pkg::S_RD_REAR: begin
        cmd.rd_sel    = tnq_pkg::RD_REAR;
        cmd.front_cap = 1'b1;
        state_next    = tnq_pkg::S_MUL;
      end
      tnq_pkg::S_MUL: begin
        cmd.rear_cap = 1'b1;
        cmd.mult     = 1'b1;
        state_next   = tnq_pkg::S_OUTPUT;
      end
      tnq_pkg::S_OUTPUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = tnq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tnq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/ticket_number_queue_unit.sv
// Top level of the take-a-number ticket queue.
// The unit keeps a circular queue of up to DEPTH 16-bit ticket numbers in one
// RAM and serves one request at a time. A take request issues the next number
// of a wrapping 16-bit counter and appends it; call removes the front entry;
// skip moves the front entry to the back; cancel removes every entry equal to
// the given number while keeping the order of the others; status changes
// nothing, and the unused opcodes behave as status. Each request yields one
// result carrying the ticket concerned, a status code, the count left, the
// front and rear numbers and two estimates built from the service time
// register. Take and status requests go from dispatch straight to the front
// and rear readback; call and skip first pass through a pop state that
// consumes the front entry. Cancel first compacts the queue: it walks the
// queue one entry per cycle through the single read port of the store, then
// drains the last read and closes the walk. Every request ends with front
// and rear readback, one multiply and the output load. The finished result
// sits in an output register and the unit is idle again in the cycle after
// loading it, so the next request is accepted while an earlier result still
// waits to be taken; a request that finishes while the previous result is
// still waiting holds in its output state until that result is taken. The
// store needs no clearing after reset, as only written entries are ever
// read. The service time register may be rewritten only while the unit is
// idle.
`timescale 1ns / 1ps
`default_nettype none
`include "ticket_number_queue_unit_macros.svh"

module ticket_number_queue_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [9:0] cfg_data,
  tnq_req_if.sink         req,
  tnq_res_if.source       res
);

  // Command and status buses between the controller and the datapath.
  tnq_pkg::cmd_t cmd;
  tnq_pkg::sts_t sts;
  logic          in_ready;

  // A request is accepted only in the idle state of the controller; the
  // payload is captured by the datapath on that same edge.
  assign req.ready = in_ready;

  tnq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath owns the ticket store, the head and count registers, the
  // ticket counter, the service time register and the result register.
  tnq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_opcode(req.opcode),
    .in_number(req.ticket_number),
    .cmd      (cmd),
    .sts      (sts),
    .res      (res)
  );

  // A request is never accepted in the cycle right after another.
  `TNQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready,
                   "request accepted on consecutive cycles")

  // A refused request never reports a ticket number.
  `TNQ_ASSERT_IMP(a_refused_no_ticket, clk, rst,
                  res.valid && (res.status != tnq_pkg::ST_OK), res.ticket == 16'd0,
                  "refused request carries a ticket number")

  // The controller never appends to a full queue.
  `TNQ_ASSERT_IMP(a_no_take_when_full, clk, rst, cmd.take, !sts.is_full,
                  "take issued on a full queue")

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the ticket number queue unit.
`timescale 1ns / 1ps

module tb_top;

  // Queue depth of the unit under test, and the opcodes that have no
  // operation of their own and must behave as a status request.
  localparam int          QUEUE_DEPTH   = 64;
  localparam logic [2:0]  OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;
  localparam int          MAX_GAP       = 16;
  // A cancel walks the whole queue and is the slowest request; the limit lies
  // far above the time of that request plus the longest stall on either side,
  // before the unit is called hung.
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          PHASE_LEN     = 125;

  // One request as planned by the stimulus. When from_queue is set the
  // driver replaces the number with one that is waiting at the moment the
  // request goes out, so that cancels usually find something to remove.
  typedef struct {
    logic [2:0]  op;
    logic [15:0] number;
    bit          from_queue;
  } request_t;

  typedef struct packed {
    logic [15:0]      ticket;
    tnq_pkg::status_t status;
    logic [6:0]       entries;
    logic [15:0]      front_no;
    logic [15:0]      rear_no;
    logic [14:0]      wait_avg;
    logic [15:0]      finish;
  } queue_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [9:0] cfg_data;

  tnq_req_if req_ch ();
  tnq_res_if res_ch ();

  ticket_number_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the unit: the tickets waiting, in order, the last number
  // issued and the service time in force.
  logic [15:0]   waiting_tickets[$];
  logic [15:0]   last_issued;
  logic [9:0]    service_minutes;

  request_t      pending_requests[$];
  queue_result_t expected_results[$];

  int            error_count;
  int            quiet_cycles;
  int            send_gap;
  int            recv_gap;
  bit            send_idles;
  bit            recv_idles;
  bit            fast_mode;
  request_t      next_request;
  queue_result_t wanted;

  // Applies one accepted request to the shadow queue and returns the result
  // that the unit must give for it.
  function automatic queue_result_t serve_request(logic [2:0] op, logic [15:0] number);
    queue_result_t r;
    logic [15:0]   kept[$];
    int unsigned   n;
    r = '0;
    r.status = tnq_pkg::ST_OK;
    case (op)
      tnq_pkg::OP_TAKE: begin
        if (waiting_tickets.size() >= QUEUE_DEPTH) begin
          r.status = tnq_pkg::ST_FULL;
        end else begin
          last_issued = last_issued + 16'd1;
          waiting_tickets.push_back(last_issued);
          r.ticket = last_issued;
        end
      end
      tnq_pkg::OP_CALL, tnq_pkg::OP_SKIP, tnq_pkg::OP_CANCEL: begin
        if (waiting_tickets.size() == 0) begin
          r.status = tnq_pkg::ST_EMPTY;
        end else if (op == tnq_pkg::OP_CALL) begin
          r.ticket = waiting_tickets.pop_front();
        end else if (op == tnq_pkg::OP_SKIP) begin
          r.ticket = waiting_tickets.pop_front();
          waiting_tickets.push_back(r.ticket);
        end else begin
          foreach (waiting_tickets[i]) begin
            if (waiting_tickets[i] != number) kept.push_back(waiting_tickets[i]);
          end
          if (kept.size() == waiting_tickets.size()) r.status = tnq_pkg::ST_NOT_FOUND;
          waiting_tickets = kept;
        end
      end
      default: ;
    endcase
    n = waiting_tickets.size();
    r.entries = 7'(n);
    if (n != 0) begin
      r.front_no = waiting_tickets[0];
      r.rear_no  = waiting_tickets[n - 1];
      r.wait_avg = 15'(((n - 1) * service_minutes) / 2);
    end
    r.finish = 16'(n * service_minutes);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Request driver. A new request is put on the channel only once the
  // previous one has been accepted, so the shadow queue is always up to date
  // when a cancel target is drawn from it. Each request is followed by a
  // random pause; pauses come in stretches, with stretches of none between.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(serve_request(req_ch.opcode, req_ch.ticket_number));
        if ($urandom_range(0, 39) == 0) send_idles = !send_idles;
        send_gap = (fast_mode || !send_idles) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_request = pending_requests.pop_front();
          if (next_request.from_queue && waiting_tickets.size() != 0)
            next_request.number =
              waiting_tickets[$urandom_range(0, waiting_tickets.size() - 1)];
          req_ch.opcode        <= next_request.op;
          req_ch.ticket_number <= next_request.number;
          req_ch.valid         <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted result is held against the oldest
  // expectation, field by field. Ready drops for a random stall after each
  // result, again in stretches.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result, expected none, got ticket %0d status %0d",
                   $time, res_ch.ticket, res_ch.status);
        end else begin
          wanted = expected_results.pop_front();
          check_field("ticket", wanted.ticket, res_ch.ticket);
          check_field("status", wanted.status, res_ch.status);
          check_field("queue_count", wanted.entries, res_ch.queue_count);
          check_field("front_ticket", wanted.front_no, res_ch.front_ticket);
          check_field("rear_ticket", wanted.rear_no, res_ch.rear_ticket);
          check_field("wait_average", wanted.wait_avg, res_ch.wait_average);
          check_field("finish_estimate", wanted.finish, res_ch.finish_estimate);
        end
        if ($urandom_range(0, 39) == 0) recv_idles = !recv_idles;
        recv_gap = (fast_mode || !recv_idles) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t ns: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic add_request(logic [2:0] op, logic [15:0] number, bit from_queue);
    request_t r;
    r.op         = op;
    r.number     = number;
    r.from_queue = from_queue;
    pending_requests.push_back(r);
  endtask

  // One request of a random mix. Every opcode value appears, the unused ones
  // included, and the number is random even where it is ignored.
  task automatic add_random_request();
    int unsigned r;
    logic [15:0] number;
    r      = $urandom_range(0, 99);
    number = 16'($urandom());
    if (r < 35) add_request(tnq_pkg::OP_TAKE, number, 1'b0);
    else if (r < 55) add_request(tnq_pkg::OP_CALL, number, 1'b0);
    else if (r < 68) add_request(tnq_pkg::OP_SKIP, number, 1'b0);
    else if (r < 83) add_request(tnq_pkg::OP_CANCEL, number, $urandom_range(0, 3) != 0);
    else if (r < 93) add_request(tnq_pkg::OP_STATUS, number, 1'b0);
    else add_request(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), number, 1'b0);
  endtask

  task automatic add_takes(int unsigned n);
    repeat (n) add_request(tnq_pkg::OP_TAKE, 16'($urandom()), 1'b0);
  endtask

  // A phase is a run of segments: bursts of takes that can push the queue into
  // the full state, bursts of calls that can run it dry, and random mixes.
  task automatic plan_phase(int unsigned n);
    int unsigned planned;
    int unsigned len;
    int unsigned kind;
    planned = 0;
    while (planned < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        len = $urandom_range(20, 70);
        add_takes(len);
      end else if (kind < 35) begin
        len = $urandom_range(20, 70);
        repeat (len) add_request(tnq_pkg::OP_CALL, 16'($urandom()), 1'b0);
      end else begin
        len = $urandom_range(10, 40);
        repeat (len) add_random_request();
      end
      planned += len;
    end
  endtask

  // Returns once every planned request has gone out and every result has
  // come back, then waits out SETTLE_CYCLES so that the unit can settle.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only ever written while the unit is idle.
  task automatic set_service_time(logic [9:0] minutes);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= minutes;
    service_minutes = minutes;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = tnq_pkg::OP_STATUS;
    req_ch.ticket_number = '0;
    res_ch.ready         = 1'b0;
    last_issued          = '0;
    service_minutes      = tnq_pkg::SERVICE_TIME_RESET;
    error_count          = 0;
    quiet_cycles         = 0;
    send_idles           = 1'b1;
    recv_idles           = 1'b1;
    fast_mode            = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset service time: every operation on an
    // empty queue, the unused opcodes, a skip, a cancel that finds its
    // number, cancels at both ends of the number range that find nothing,
    // calls until empty, and a cancel that empties the queue.
    add_request(tnq_pkg::OP_STATUS, 16'hFFFF, 1'b0);
    add_request(tnq_pkg::OP_CALL, 16'h0000, 1'b0);
    add_request(tnq_pkg::OP_SKIP, 16'hFFFF, 1'b0);
    add_request(tnq_pkg::OP_CANCEL, 16'h0000, 1'b0);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      add_request(3'(op), 16'($urandom()), 1'b0);
    add_takes(3);
    add_request(tnq_pkg::OP_STATUS, 16'h0000, 1'b0);
    add_request(tnq_pkg::OP_SKIP, 16'h0000, 1'b0);
    add_request(tnq_pkg::OP_CANCEL, 16'd2, 1'b0);
    add_request(tnq_pkg::OP_CANCEL, 16'hFFFF, 1'b0);
    add_takes(1);
    add_request(tnq_pkg::OP_CANCEL, 16'h0000, 1'b0);
    repeat (4) add_request(tnq_pkg::OP_CALL, 16'hFFFF, 1'b0);
    add_takes(1);
    add_request(tnq_pkg::OP_CANCEL, 16'd5, 1'b0);
    add_request(tnq_pkg::OP_STATUS, 16'hFFFF, 1'b0);
    wait_drained();

    // Largest service time, with the queue driven full straight away so
    // that both estimates reach their top values.
    set_service_time(10'd1023);
    add_takes(70);
    plan_phase(PHASE_LEN);
    wait_drained();

    set_service_time(10'd0);
    plan_phase(PHASE_LEN);
    wait_drained();

    set_service_time(10'd1);
    plan_phase(PHASE_LEN);
    wait_drained();

    set_service_time(10'($urandom_range(2, 1022)));
    plan_phase(PHASE_LEN);
    wait_drained();

    // One random phase runs flat out, without pauses on either side.
    set_service_time(10'($urandom_range(0, 1023)));
    fast_mode = 1'b1;
    plan_phase(PHASE_LEN);
    wait_drained();
    fast_mode = 1'b0;

    set_service_time(tnq_pkg::SERVICE_TIME_RESET);
    plan_phase(PHASE_LEN);
    wait_drained();

    if (expected_results.size() != 0) begin
      error_count++;
      $display("%0t ns: results outstanding, expected 0, got %0d",
               $time, expected_results.size());
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
